>>> design/sgdps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SGD parameter store package
// Shared operation codes, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package sgdps_pkg;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEARN_RATE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_WORKERS = 2'd2;
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;
    localparam int RATE_BITS = 16;
    localparam int NW_BITS = 5;
    localparam int TAG_BITS = 8;
    localparam int FRAC_BITS = 16;
endpackage
`default_nettype wire

>>> design/sgdps_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SGD parameter store step divider
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module sgdps_div #(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 24
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    output logic                     o_done,
    output logic [NUM_BITS-1:0]      o_quo
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);
    logic [NUM_BITS-1:0] r_q, n_q;
    logic [DEN_BITS:0]   r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy, r_done, n_done;
    logic [DEN_BITS:0]   w_trial;

    always_comb begin
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[DEN_BITS-1:0], r_q[NUM_BITS-1]};
        if (i_start) begin
            n_q = i_num;
            n_rem = '0;
            n_cnt = CNT_BITS'(NUM_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_q = {r_q[NUM_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q = {r_q[NUM_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo = r_q;
endmodule
`default_nettype wire

>>> design/sgd_parameter_store_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SGD parameter store
// Weight and merge memories with a read-modify-write SGD update sequencer.
// ----------------------------------------------------------------------------
// One item at a time. Each of these passes from READ straight to OUT,
// where its result enters the output register:
//   - a pull,
//   - an initializing push,
//   - a synchronous push that does not close a round.
// An updating push passes through MUL, DIV and WRITE before OUT. The
// bit-serial divider in DIV forms rate*x/(count*2^16) with rounding. The
// next item is taken the cycle after the result enters the output
// register. The register holds while the output is stalled.
// After reset, a clearing pass over all TABLE_DEPTH entries zeroes the
// weights and merge tags. After every 255th synchronous round, a pass over
// all entries sweeps the merge tags. No item is accepted during either pass.
module sgd_parameter_store_top #(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_WORKERS = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [sgdps_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [sgdps_pkg::RATE_BITS-1:0]    i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_op,
    input  wire logic [9:0]                     i_key,
    input  wire logic signed [VALUE_BITS-1:0]   i_value,
    input  wire logic                           i_last,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [VALUE_BITS-1:0]        o_read_value,
    output logic [4:0]                          o_acks_released,
    output logic                                o_error,
    output logic                                o_end_of_request
);
    import sgdps_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WB = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS + 1) : 1;
    localparam int DEN_BITS = WB + FRAC_BITS;
    localparam int NUM_BITS = VALUE_BITS + RATE_BITS + 1;
    localparam int PROD_BITS = VALUE_BITS + RATE_BITS;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic signed [VALUE_BITS:0] VMAX = {2'b00, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS:0] VMIN = {2'b11, {(VALUE_BITS-1){1'b0}}};

    logic signed [VALUE_BITS-1:0] r_wmem [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0] r_mmem [TABLE_DEPTH];
    logic [TAG_BITS-1:0]          r_tmem [TABLE_DEPTH];

    logic [2:0]                   r_state;
    logic                         r_sync;
    logic [RATE_BITS-1:0]         r_rate;
    logic [NW_BITS-1:0]           r_nw;
    logic [TAG_BITS-1:0]          r_round;
    logic [WB-1:0]                r_reqs;
    logic                         r_init;
    logic [AW-1:0]                r_clr;

    logic                         r_op, r_last;
    logic [AW-1:0]                r_key;
    logic signed [VALUE_BITS-1:0] r_val;
    logic signed [VALUE_BITS-1:0] r_wrd, r_mrd;
    logic [TAG_BITS-1:0]          r_trd;
    logic signed [VALUE_BITS-1:0] r_sum;
    logic                         r_neg;
    logic                         r_start;
    logic [PROD_BITS-1:0]         r_prod;
    logic [WB-1:0]                r_cnt;
    logic                         r_final;

    logic signed [VALUE_BITS-1:0] r_sord;
    logic [4:0]                   r_sack;
    logic                         r_serr;

    logic                         r_ovalid;
    logic signed [VALUE_BITS-1:0] r_ord;
    logic [4:0]                   r_oack;
    logic                         r_oerr, r_olast;

    logic                         w_accept;
    logic [WB-1:0]                w_count;
    logic signed [VALUE_BITS:0]   w_sum_wide, w_msum;
    logic signed [VALUE_BITS-1:0] w_msum_sat;
    logic [VALUE_BITS-1:0]        w_mag;
    logic                         w_div_start, w_div_done;
    logic [NUM_BITS-1:0]          w_num, w_quo;
    logic [DEN_BITS-1:0]          w_den;
    logic signed [VALUE_BITS+1:0] w_step, w_new;
    logic signed [VALUE_BITS-1:0] w_new_sat;
    logic                         w_out_free;

    always_comb begin
        if (r_nw == '0) begin
            w_count = WB'(1);
        end else if (32'(r_nw) > MAX_WORKERS) begin
            w_count = WB'(MAX_WORKERS);
        end else begin
            w_count = WB'(r_nw);
        end
    end

    assign w_out_free = !r_ovalid || i_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept = i_valid && o_ready;

    // merge accumulate with saturation
    always_comb begin
        w_msum = {r_trd == r_round ? r_mrd[VALUE_BITS-1] : 1'b0,
                  (r_trd == r_round) ? r_mrd : {VALUE_BITS{1'b0}}};
        w_sum_wide = w_msum + {r_val[VALUE_BITS-1], r_val};
        if (w_sum_wide > VMAX) begin
            w_msum_sat = VMAX[VALUE_BITS-1:0];
        end else if (w_sum_wide < VMIN) begin
            w_msum_sat = VMIN[VALUE_BITS-1:0];
        end else begin
            w_msum_sat = w_sum_wide[VALUE_BITS-1:0];
        end
    end

    assign w_mag = r_sum[VALUE_BITS-1] ? (~r_sum + 1'b1) : r_sum;
    assign w_den = {r_cnt, {FRAC_BITS{1'b0}}};
    assign w_num = {1'b0, r_prod} + NUM_BITS'({r_cnt, {(FRAC_BITS-1){1'b0}}});
    assign w_div_start = r_start;

    sgdps_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (DEN_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        if (w_quo[NUM_BITS-1:VALUE_BITS] != '0) begin
            w_step = {2'b00, {VALUE_BITS{1'b1}}};
        end else begin
            w_step = {2'b00, w_quo[VALUE_BITS-1:0]};
        end
        if (r_neg) begin
            w_new = {{2{r_wrd[VALUE_BITS-1]}}, r_wrd} + w_step;
        end else begin
            w_new = {{2{r_wrd[VALUE_BITS-1]}}, r_wrd} - w_step;
        end
        if (w_new > $signed({VMAX[VALUE_BITS], VMAX})) begin
            w_new_sat = VMAX[VALUE_BITS-1:0];
        end else if (w_new < $signed({VMIN[VALUE_BITS], VMIN})) begin
            w_new_sat = VMIN[VALUE_BITS-1:0];
        end else begin
            w_new_sat = w_new[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_tmem[r_clr] <= '0;
        end else if (r_state == ST_READ && r_op == OP_PUSH && r_init && r_sync) begin
            r_mmem[r_key] <= w_msum_sat;
            r_tmem[r_key] <= r_round;
        end
        if (r_state == ST_CLEAR && !r_init) begin
            r_wmem[r_clr] <= '0;
        end else if (r_state == ST_READ && r_op == OP_PUSH && !r_init) begin
            r_wmem[r_key] <= r_val;
        end else if (r_state == ST_WRITE) begin
            r_wmem[r_key] <= w_new_sat;
        end
        if (w_accept) begin
            r_wrd <= r_wmem[AW'(32'(i_key) % TABLE_DEPTH)];
            r_mrd <= r_mmem[AW'(32'(i_key) % TABLE_DEPTH)];
            r_trd <= r_tmem[AW'(32'(i_key) % TABLE_DEPTH)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_sync   <= 1'b1;
            r_rate   <= RATE_BITS'(655);
            r_nw     <= NW_BITS'(1);
            r_round  <= TAG_BITS'(1);
            r_reqs   <= '0;
            r_init   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SYNC_MODE:   r_sync <= i_cfg_data[0];
                    REG_LEARN_RATE:  r_rate <= i_cfg_data;
                    REG_NUM_WORKERS: r_nw <= i_cfg_data[NW_BITS-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_READ) begin
                r_sord <= (r_op == OP_PULL && r_init) ? r_wrd : '0;
                r_serr <= (r_op == OP_PULL) && !r_init;
            end
            case (r_state)
                ST_CLEAR: begin
                    if (32'(r_clr) == TABLE_DEPTH - 1) begin
                        r_clr <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (r_op == OP_PULL) begin
                        r_sack <= '0;
                        r_final <= 1'b0;
                        r_state <= ST_OUT;
                    end else if (!r_init) begin
                        if (r_last) begin
                            r_init <= 1'b1;
                        end
                        r_sack <= r_last ? 5'd1 : 5'd0;
                        r_final <= 1'b0;
                        r_state <= ST_OUT;
                    end else if (!r_sync) begin
                        r_sack <= r_last ? 5'd1 : 5'd0;
                        r_cnt <= WB'(1);
                        r_sum <= r_val;
                        r_final <= 1'b0;
                        r_state <= ST_MUL;
                    end else begin
                        r_cnt <= w_count;
                        r_sum <= w_msum_sat;
                        if (r_reqs + 1'b1 >= w_count) begin
                            r_final <= 1'b1;
                            r_state <= ST_MUL;
                            r_sack <= r_last ? 5'(w_count) : 5'd0;
                            if (r_last) begin
                                r_reqs <= '0;
                                if (r_round == {TAG_BITS{1'b1}}) begin
                                    r_round <= TAG_BITS'(1);
                                end else begin
                                    r_round <= r_round + 1'b1;
                                end
                            end
                        end else begin
                            r_final <= 1'b0;
                            r_sack <= '0;
                            r_state <= ST_OUT;
                            if (r_last) begin
                                r_reqs <= r_reqs + 1'b1;
                            end
                        end
                    end
                end
                ST_MUL: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_ord <= r_sord;
                        r_oack <= r_sack;
                        r_oerr <= r_serr;
                        r_olast <= r_last;
                        if (r_final && r_last && r_round == TAG_BITS'(1)) begin
                            r_state <= ST_CLEAR;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_op;
            r_key  <= AW'(32'(i_key) % TABLE_DEPTH);
            r_val  <= i_value;
            r_last <= i_last;
        end
        if (r_state == ST_READ) begin
            r_neg <= 1'b0;
        end
        if (r_state == ST_MUL) begin
            r_neg <= r_sum[VALUE_BITS-1];
        end
        r_start <= (r_state == ST_MUL);
    end

    // multiply registered ahead of the divider start
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_prod <= PROD_BITS'(w_mag) * PROD_BITS'(r_rate);
        end
    end

    assign o_valid = r_ovalid;
    assign o_read_value = r_ord;
    assign o_acks_released = r_oack;
    assign o_error = r_oerr;
    assign o_end_of_request = r_olast;
endmodule
`default_nettype wire

>>> design/sgdps_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SGD parameter store checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module sgdps_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_error,
    input wire logic [31:0] o_read_value,
    input wire logic [4:0]  o_acks_released
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_read_value == '0 && o_acks_released == '0)
        else $error("error result carries data");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("second item taken");
    a_ack_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_acks_released <= 5'd16)
        else $error("ack out of range");
endmodule

bind sgd_parameter_store_top sgdps_checker u_chk (
    .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (i_valid), .o_ready (o_ready),
    .o_valid (o_valid), .i_ready (i_ready), .o_error (o_error),
    .o_read_value (o_read_value), .o_acks_released (o_acks_released)
);
`default_nettype wire
